[design/ctc_pkg.sv]
// Shared byte codes, parser mode codes and cell layout for the character terminal controller.
package ctc_pkg;

  // Control bytes seen in normal mode.
  localparam logic [7:0] BYTE_FWD   = 8'h04;
  localparam logic [7:0] BYTE_BELL  = 8'h07;
  localparam logic [7:0] BYTE_BS    = 8'h08;
  localparam logic [7:0] BYTE_LF    = 8'h0a;
  localparam logic [7:0] BYTE_CR    = 8'h0d;
  localparam logic [7:0] BYTE_SO    = 8'h0e;
  localparam logic [7:0] BYTE_SI    = 8'h0f;
  localparam logic [7:0] BYTE_SUBND = 8'h19;
  localparam logic [7:0] BYTE_HOME  = 8'h1a;
  localparam logic [7:0] BYTE_ESC   = 8'h1b;
  localparam logic [7:0] BYTE_SPACE = 8'h20;
  localparam logic [7:0] BYTE_LOW_A = 8'h61;
  localparam logic [7:0] BYTE_LOW_Z = 8'h7a;

  // Escape codes.
  localparam logic [7:0] ESC_POS    = 8'h3d;  // '='
  localparam logic [7:0] ESC_CLEAR  = 8'h2b;  // '+'
  localparam logic [7:0] ESC_INS    = 8'h45;  // 'E'
  localparam logic [7:0] ESC_DEL    = 8'h52;  // 'R'
  localparam logic [7:0] ESC_HIGH   = 8'h47;  // 'G'
  localparam logic [7:0] ESC_SUB    = 8'h7c;  // '|'
  localparam logic [7:0] HIGH_ARG   = 8'h32;  // '2'

  // Parser modes.
  localparam logic [2:0] MODE_NORMAL = 3'd0;
  localparam logic [2:0] MODE_ESC    = 3'd2;
  localparam logic [2:0] MODE_POS    = 3'd3;
  localparam logic [2:0] MODE_SUB    = 3'd4;
  localparam logic [2:0] MODE_HIGH   = 3'd5;

  // Commands.
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // One screen cell: highlight bit above the character.
  typedef struct packed {
    logic       hl;
    logic [7:0] ch;
  } cell_t;

  localparam cell_t BLANK_CELL = '{hl: 1'b0, ch: BYTE_SPACE};

endpackage

[design/ctc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ctc_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 1920
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/character_terminal_controller_unit.sv]
// Top level of the character terminal controller: parser, cursor and screen sweep sequencer.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------------------
//   in      | input     | in_valid / in_stall  | command, rx_byte, read_row, read_col
//   out     | output    | out_valid / out_stall| cell_char, cell_highlight, cursor_row,
//           |           |                      | cursor_col, upper_case_on, bell
//
// Cursor and mode updates and cell reads go straight to the result; a printable write passes S_WR.
// A clear blanks the cells in turn; a scroll or line move copies the cells it moves by a read and
// a write each, then blanks a row; a highlight reads and writes each cell; the single RAM port pair forces this.
// After reset a clearing pass over all ROWS*COLS cells runs before the first item is taken.
// One item is worked at a time; in_stall is high until the sequencer is idle again.
// A finished result waits in the output register while the next item is accepted.
module character_terminal_controller_unit
  import ctc_pkg::*;
#(
  parameter int ROWS = 24,
  parameter int COLS = 80
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       command,
  input  logic [7:0] rx_byte,
  input  logic [4:0] read_row,
  input  logic [6:0] read_col,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] cell_char,
  output logic       cell_highlight,
  output logic [4:0] cursor_row,
  output logic [6:0] cursor_col,
  output logic       upper_case_on,
  output logic       bell
);

  localparam int NCELLS = ROWS * COLS;
  localparam int AW     = $clog2(NCELLS);
  localparam int RW     = $clog2(ROWS);
  localparam int CCW    = $clog2(COLS + 1);

  localparam logic [CCW-1:0] COL_END  = CCW'(COLS);
  localparam logic [RW-1:0]  ROW_LAST = RW'(ROWS - 1);
  localparam logic [7:0]     ROW_MAX8 = 8'(ROWS - 1);
  localparam logic [7:0]     COL_MAX8 = 8'(COLS - 1);
  localparam logic [AW-1:0]  ADDR_LAST    = AW'(NCELLS - 1);
  localparam logic [AW-1:0]  LAST_ROW_LO  = AW'((ROWS - 1) * COLS);
  localparam logic [AW-1:0]  COPY_UP_END  = AW'((ROWS - 1) * COLS - 1);
  localparam logic [AW-1:0]  ROW_SPAN     = AW'(COLS);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_BLANK = 3'd1;
  localparam logic [2:0] S_CPR   = 3'd2;
  localparam logic [2:0] S_CPW   = 3'd3;
  localparam logic [2:0] S_HLR   = 3'd4;
  localparam logic [2:0] S_HLW   = 3'd5;
  localparam logic [2:0] S_WR    = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]     state;
  logic [RW-1:0]  cur_row;
  logic [CCW-1:0] cur_col;
  logic [2:0]     parse_mode;
  logic [1:0]     args_left;
  logic           upper_flag;

  // Sweep registers: current address, last address, direction and the blank run after a copy.
  logic [AW-1:0]  addr;
  logic [AW-1:0]  end_addr;
  logic           copy_down;
  logic [AW-1:0]  blk_lo;
  logic [AW-1:0]  blk_hi;
  logic           respond;
  cell_t          wdata;

  // Per-item result bookkeeping.
  logic           is_read;
  logic           in_range;
  logic           bell_hit;

  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  cell_t          ram_wdata;
  logic [AW-1:0]  ram_raddr;
  cell_t          ram_rdata;
  logic [AW-1:0]  src_addr;

  logic           accept;
  logic           result_load;
  logic [AW-1:0]  row_base;
  logic [AW-1:0]  cur_addr;
  logic [AW-1:0]  rd_cell_addr;
  logic [7:0]     arg_v;
  logic [7:0]     arg_row;
  logic [7:0]     arg_col;
  logic [7:0]     print_ch;
  logic [7:0]     col8;

  ctc_ram #(
    .WIDTH($bits(cell_t)),
    .DEPTH(NCELLS)
  ) u_screen (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_stall    = (state != S_IDLE);
  assign accept      = in_valid && !in_stall;
  assign result_load = (state == S_DONE) && (!out_valid || !out_stall);

  assign row_base     = AW'(32'(cur_row) * COLS);
  assign cur_addr     = AW'(32'(cur_row) * COLS + 32'(cur_col));
  assign rd_cell_addr = AW'(32'(read_row) * COLS + 32'(read_col));

  // Position argument: byte minus space, floored at zero, then saturated.
  assign arg_v   = (rx_byte < BYTE_SPACE) ? 8'd0 : (rx_byte - BYTE_SPACE);
  assign arg_row = (arg_v > ROW_MAX8) ? ROW_MAX8 : arg_v;
  assign arg_col = (arg_v > COL_MAX8) ? COL_MAX8 : arg_v;

  assign print_ch = (upper_flag && rx_byte >= BYTE_LOW_A && rx_byte <= BYTE_LOW_Z) ?
                    (rx_byte - BYTE_SPACE) : rx_byte;

  // Source of a row move is one row below (scroll up) or above (open a line).
  // While idle the port reads the cell an incoming item needs: the requested cell for
  // a read, the cursor cell for a byte so a printable write keeps its attribute.
  assign src_addr  = copy_down ? (addr - ROW_SPAN) : (addr + ROW_SPAN);
  assign ram_raddr = (state == S_CPR)  ? src_addr :
                     (state == S_IDLE) ? ((command == CMD_READ) ? rd_cell_addr : cur_addr) :
                     addr;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr;
    ram_wdata = BLANK_CELL;
    case (state)
      S_BLANK: begin
        ram_we = 1'b1;
      end
      S_CPW: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
      end
      S_HLW: begin
        ram_we    = 1'b1;
        ram_wdata = '{hl: 1'b1, ch: ram_rdata.ch};
      end
      S_WR: begin
        ram_we    = 1'b1;
        ram_wdata = '{hl: ram_rdata.hl, ch: wdata.ch};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_BLANK;
      addr       <= '0;
      end_addr   <= ADDR_LAST;
      respond    <= 1'b0;
      cur_row    <= '0;
      cur_col    <= '0;
      parse_mode <= MODE_NORMAL;
      args_left  <= 2'd0;
      upper_flag <= 1'b1;
      out_valid  <= 1'b0;
      is_read    <= 1'b0;
      in_range   <= 1'b0;
      bell_hit   <= 1'b0;
      copy_down  <= 1'b0;
      blk_lo     <= '0;
      blk_hi     <= '0;
    end else begin
      if (result_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            respond  <= 1'b1;
            bell_hit <= 1'b0;
            is_read  <= (command == CMD_READ);
            in_range <= 1'b0;
            state    <= S_DONE;
            if (command == CMD_READ) begin
              // The cell is read at this edge; keeping the address holds it while stalled.
              in_range <= (32'(read_row) < ROWS) && (32'(read_col) < COLS);
              addr     <= rd_cell_addr;
            end else begin
              case (parse_mode)
                MODE_NORMAL: begin
                  if (rx_byte >= BYTE_SPACE) begin
                    if (cur_col < COL_END) begin
                      addr    <= cur_addr;
                      wdata   <= '{hl: 1'b0, ch: print_ch};
                      cur_col <= cur_col + 1'b1;
                      state   <= S_WR;
                    end
                  end else begin
                    case (rx_byte)
                      BYTE_FWD: begin
                        if (cur_col < COL_END) cur_col <= cur_col + 1'b1;
                      end
                      BYTE_BELL: bell_hit <= 1'b1;
                      BYTE_BS: begin
                        if (cur_col != '0) cur_col <= cur_col - 1'b1;
                      end
                      BYTE_SO: upper_flag <= 1'b0;
                      BYTE_SI: upper_flag <= 1'b1;
                      BYTE_LF, BYTE_CR: begin
                        if (rx_byte == BYTE_CR) cur_col <= '0;
                        if (cur_row < ROW_LAST) begin
                          cur_row <= cur_row + 1'b1;
                        end else begin
                          // Scroll: move every row up one, then blank the last row.
                          addr      <= '0;
                          end_addr  <= COPY_UP_END;
                          copy_down <= 1'b0;
                          blk_lo    <= LAST_ROW_LO;
                          blk_hi    <= ADDR_LAST;
                          state     <= S_CPR;
                        end
                      end
                      BYTE_HOME: begin
                        cur_row  <= '0;
                        cur_col  <= '0;
                        addr     <= '0;
                        end_addr <= ADDR_LAST;
                        state    <= S_BLANK;
                      end
                      BYTE_ESC: parse_mode <= MODE_ESC;
                      default: begin
                      end
                    endcase
                  end
                end
                MODE_ESC: begin
                  parse_mode <= MODE_NORMAL;
                  case (rx_byte)
                    ESC_SUB: begin
                      parse_mode <= MODE_SUB;
                      args_left  <= 2'd0;
                    end
                    ESC_POS: begin
                      parse_mode <= MODE_POS;
                      args_left  <= 2'd2;
                    end
                    ESC_CLEAR: begin
                      addr     <= '0;
                      end_addr <= ADDR_LAST;
                      state    <= S_BLANK;
                    end
                    ESC_HIGH: parse_mode <= MODE_HIGH;
                    ESC_INS: begin
                      // Open a line: rows below shift down from the bottom upward.
                      blk_lo <= row_base;
                      blk_hi <= row_base + ROW_SPAN - 1'b1;
                      if (cur_row == ROW_LAST) begin
                        addr     <= row_base;
                        end_addr <= row_base + ROW_SPAN - 1'b1;
                        state    <= S_BLANK;
                      end else begin
                        addr      <= ADDR_LAST;
                        end_addr  <= row_base + ROW_SPAN;
                        copy_down <= 1'b1;
                        state     <= S_CPR;
                      end
                    end
                    ESC_DEL: begin
                      blk_lo <= LAST_ROW_LO;
                      blk_hi <= ADDR_LAST;
                      if (cur_row == ROW_LAST) begin
                        addr     <= LAST_ROW_LO;
                        end_addr <= ADDR_LAST;
                        state    <= S_BLANK;
                      end else begin
                        addr      <= row_base;
                        end_addr  <= COPY_UP_END;
                        copy_down <= 1'b0;
                        state     <= S_CPR;
                      end
                    end
                    default: begin
                    end
                  endcase
                end
                MODE_POS: begin
                  if (args_left == 2'd2) begin
                    cur_row   <= RW'(arg_row);
                    args_left <= 2'd1;
                  end else if (args_left == 2'd1) begin
                    cur_col    <= CCW'(arg_col);
                    args_left  <= 2'd0;
                    parse_mode <= MODE_NORMAL;
                  end else begin
                    parse_mode <= MODE_NORMAL;
                  end
                end
                MODE_SUB: begin
                  if (rx_byte == BYTE_SUBND) parse_mode <= MODE_NORMAL;
                end
                MODE_HIGH: begin
                  parse_mode <= MODE_NORMAL;
                  if (rx_byte == HIGH_ARG && cur_col < COL_END) begin
                    addr     <= cur_addr;
                    end_addr <= row_base + ROW_SPAN - 1'b1;
                    state    <= S_HLR;
                  end
                end
                default: parse_mode <= MODE_NORMAL;
              endcase
            end
          end
        end
        S_BLANK: begin
          if (addr == end_addr) begin
            state <= respond ? S_DONE : S_IDLE;
          end else begin
            addr <= addr + 1'b1;
          end
        end
        S_CPR: begin
          state <= S_CPW;
        end
        S_CPW: begin
          if (addr == end_addr) begin
            addr     <= blk_lo;
            end_addr <= blk_hi;
            state    <= S_BLANK;
          end else begin
            addr  <= copy_down ? (addr - 1'b1) : (addr + 1'b1);
            state <= S_CPR;
          end
        end
        S_HLR: begin
          state <= S_HLW;
        end
        S_HLW: begin
          if (addr == end_addr) begin
            state <= S_DONE;
          end else begin
            addr  <= addr + 1'b1;
            state <= S_HLR;
          end
        end
        S_WR: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (result_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign col8 = 8'(cur_col);

  // Result payload is loaded together with out_valid.
  always_ff @(posedge clk) begin
    if (result_load) begin
      cell_char      <= (is_read && in_range) ? ram_rdata.ch : 8'd0;
      cell_highlight <= is_read && in_range && ram_rdata.hl;
      cursor_row     <= 5'(cur_row);
      cursor_col     <= col8[6:0];
      upper_case_on  <= upper_flag;
      bell           <= bell_hit;
    end
  end

endmodule

[bench/ctc_checker.sv]
// Screen predictor and result checker for the character terminal controller.
`timescale 1ns / 100ps
module ctc_checker
  import ctc_pkg::*;
#(
  parameter int ROWS = 24,
  parameter int COLS = 80
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic       command,
  input  logic [7:0] rx_byte,
  input  logic [4:0] read_row,
  input  logic [6:0] read_col,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] cell_char,
  input  logic       cell_highlight,
  input  logic [4:0] cursor_row,
  input  logic [6:0] cursor_col,
  input  logic       upper_case_on,
  input  logic       bell,
  output int         fail_count,
  output int         pending
);

  typedef struct packed {
    logic [7:0] ch;
    logic       hl;
    logic [4:0] row;
    logic [6:0] col;
    logic       upper;
    logic       bell;
  } status_t;

  cell_t   scr [ROWS*COLS];
  int      crow, ccol, mode, args_rem;
  bit      upper;
  status_t status_q[$];

  assign pending = status_q.size();

  function automatic void blank_all();
    foreach (scr[i]) scr[i] = BLANK_CELL;
  endfunction

  function automatic void blank_line(int r);
    for (int c = 0; c < COLS; c++) scr[r*COLS+c] = BLANK_CELL;
  endfunction

  // Lines below r move up by one; the bottom line goes blank.
  function automatic void pull_up(int r);
    for (int i = r*COLS; i < (ROWS-1)*COLS; i++) scr[i] = scr[i+COLS];
    blank_line(ROWS-1);
  endfunction

  function automatic void push_down(int r);
    for (int i = ROWS*COLS-1; i >= (r+1)*COLS; i--) scr[i] = scr[i-COLS];
    blank_line(r);
  endfunction

  function automatic void next_line();
    if (crow < ROWS-1) crow++;
    else pull_up(0);
  endfunction

  function automatic int clamp_arg(int b, int lim);
    int v;
    v = (b < 32) ? 0 : b - 32;
    return (v > lim) ? lim : v;
  endfunction

  function automatic bit feed_byte(logic [7:0] b);
    bit rang;
    rang = 0;
    case (mode)
      MODE_NORMAL: begin
        if (b >= BYTE_SPACE) begin
          if (ccol < COLS) begin
            if (upper && b >= BYTE_LOW_A && b <= BYTE_LOW_Z) b = b - 8'h20;
            scr[crow*COLS+ccol].ch = b;
            ccol++;
          end
        end else begin
          case (b)
            BYTE_FWD:  if (ccol < COLS) ccol++;
            BYTE_BELL: rang = 1;
            BYTE_BS:   if (ccol > 0) ccol--;
            BYTE_SO:   upper = 0;
            BYTE_SI:   upper = 1;
            BYTE_LF:   next_line();
            BYTE_CR: begin
              ccol = 0;
              next_line();
            end
            BYTE_HOME: begin
              blank_all();
              crow = 0;
              ccol = 0;
            end
            BYTE_ESC:  mode = MODE_ESC;
            default: ;
          endcase
        end
      end
      MODE_ESC: begin
        mode = MODE_NORMAL;
        case (b)
          ESC_SUB: begin
            mode = MODE_SUB;
            args_rem = 0;
          end
          ESC_POS: begin
            mode = MODE_POS;
            args_rem = 2;
          end
          ESC_CLEAR: blank_all();
          ESC_HIGH:  mode = MODE_HIGH;
          ESC_INS:   push_down(crow);
          ESC_DEL:   pull_up(crow);
          default: ;
        endcase
      end
      MODE_POS: begin
        if (args_rem == 2) crow = clamp_arg(b, ROWS-1);
        else if (args_rem == 1) ccol = clamp_arg(b, COLS-1);
        if (args_rem != 0) args_rem--;
        if (args_rem == 0) mode = MODE_NORMAL;
      end
      MODE_SUB: if (b == BYTE_SUBND) mode = MODE_NORMAL;
      MODE_HIGH: begin
        if (b == HIGH_ARG)
          for (int c = ccol; c < COLS; c++) scr[crow*COLS+c].hl = 1'b1;
        mode = MODE_NORMAL;
      end
      default: mode = MODE_NORMAL;
    endcase
    return rang;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    status_t s, e;
    if (rst) begin
      blank_all();
      crow = 0;
      ccol = 0;
      mode = MODE_NORMAL;
      args_rem = 0;
      upper = 1;
      status_q.delete();
      fail_count = 0;
    end else begin
      if (in_valid && !in_stall) begin
        s = '0;
        if (command == CMD_BYTE) begin
          s.bell = feed_byte(rx_byte);
        end else if (read_row < ROWS && read_col < COLS) begin
          s.ch = scr[read_row*COLS+read_col].ch;
          s.hl = scr[read_row*COLS+read_col].hl;
        end
        s.row = crow[4:0];
        s.col = ccol[6:0];
        s.upper = upper;
        status_q.push_back(s);
      end
      if (out_valid && !out_stall) begin
        if (status_q.size() == 0) begin
          report("unexpected result count", 1, 0);
        end else begin
          e = status_q.pop_front();
          if (cell_char !== e.ch) report("cell_char", cell_char, e.ch);
          if (cell_highlight !== e.hl) report("cell_highlight", cell_highlight, e.hl);
          if (cursor_row !== e.row) report("cursor_row", cursor_row, e.row);
          if (cursor_col !== e.col) report("cursor_col", cursor_col, e.col);
          if (upper_case_on !== e.upper) report("upper_case_on", upper_case_on, e.upper);
          if (bell !== e.bell) report("bell", bell, e.bell);
        end
      end
    end
  end

endmodule

[bench/tb_top.sv]
// Stimulus and verdict for the character terminal controller testbench.
`timescale 1ns / 100ps
module tb_top;
  import ctc_pkg::*;

  localparam int ROWS = 24;
  localparam int COLS = 80;

  logic       clk = 0;
  logic       rst = 1;
  logic       in_valid = 0;
  logic       in_stall;
  logic       command = CMD_BYTE;
  logic [7:0] rx_byte = '0;
  logic [4:0] read_row = '0;
  logic [6:0] read_col = '0;
  logic       out_valid;
  logic       out_stall = 0;
  logic [7:0] cell_char;
  logic       cell_highlight;
  logic [4:0] cursor_row;
  logic [6:0] cursor_col;
  logic       upper_case_on;
  logic       bell;
  int         fail_count;
  int         pending;

  // Set while the receiver is forced into its long hold-off.
  bit         hold_off = 0;
  bit         stim_done = 0;

  always #1 clk = ~clk;

  character_terminal_controller_unit #(.ROWS(ROWS), .COLS(COLS)) uut (.*);

  ctc_checker #(.ROWS(ROWS), .COLS(COLS)) checker_i (.*);

  // The stimulus is a list of items built up front, then driven in bursts.
  typedef struct packed {
    logic       cmd;
    logic [7:0] b;
    logic [4:0] r;
    logic [6:0] c;
  } item_t;

  item_t items[$];

  function automatic void add_byte(logic [7:0] b);
    items.push_back('{cmd: CMD_BYTE, b: b, r: 5'($urandom), c: 7'($urandom)});
  endfunction

  // A read mostly lands on the screen, but sometimes anywhere in the field range.
  function automatic void add_read();
    item_t it;
    it.cmd = CMD_READ;
    it.b = 8'($urandom);
    if ($urandom_range(0, 7) == 0) begin
      it.r = 5'($urandom);
      it.c = 7'($urandom);
    end else begin
      it.r = 5'($urandom_range(0, ROWS-1));
      it.c = 7'($urandom_range(0, COLS-1));
    end
    items.push_back(it);
  endfunction

  function automatic void build_directed();
    // Write a lower-case letter with conversion on, another with it off, then turn it back on.
    add_byte("a");
    add_byte(BYTE_SO);
    add_byte("z");
    add_byte(BYTE_SI);
    add_byte(8'hff);
    add_byte(BYTE_BELL);
    add_byte(BYTE_BS);
    add_byte(BYTE_FWD);
    add_byte(8'h00);  // unknown control code is ignored
    // Position to the bottom row with a saturated row and a floored column argument, then write.
    add_byte(BYTE_ESC);
    add_byte(ESC_POS);
    add_byte(8'hff);
    add_byte(8'h05);
    add_byte(BYTE_FWD);
    add_byte(BYTE_FWD);
    add_byte("x");
    add_byte(BYTE_ESC);
    add_byte(ESC_HIGH);
    add_byte(HIGH_ARG);
    add_byte(BYTE_CR);  // scrolls from the bottom row
    add_byte(BYTE_ESC);
    add_byte(ESC_SUB);
    add_byte(BYTE_ESC);
    add_byte(BYTE_SUBND);
    add_read();
  endfunction

  // Well-formed sequences with random content make up most of the random part.
  function automatic void build_random(int n);
    int k;
    while (items.size() < n) begin
      k = $urandom_range(0, 19);
      case (k)
        0, 1, 2, 3: add_byte(8'($urandom_range(8'h20, 8'hff)));
        4, 5, 6: add_read();
        7: begin
          add_byte(BYTE_ESC);
          add_byte(ESC_POS);
          add_byte(8'($urandom_range(0, 60)));
          add_byte(8'($urandom));
        end
        8: begin
          add_byte(BYTE_ESC);
          add_byte(ESC_HIGH);
          add_byte($urandom_range(0, 2) != 0 ? HIGH_ARG : 8'($urandom));
        end
        9: begin
          add_byte(BYTE_ESC);
          add_byte($urandom_range(0, 1) ? ESC_INS : ESC_DEL);
        end
        10: begin
          add_byte(BYTE_ESC);
          add_byte(ESC_SUB);
          repeat ($urandom_range(0, 3)) add_byte(8'($urandom));
          add_byte(BYTE_SUBND);
        end
        11: add_byte($urandom_range(0, 1) ? BYTE_CR : BYTE_LF);
        12: add_byte($urandom_range(0, 1) ? BYTE_SO : BYTE_SI);
        13: add_byte($urandom_range(0, 1) ? BYTE_FWD : BYTE_BS);
        14: add_byte(BYTE_BELL);
        15: begin
          add_byte(BYTE_ESC);
          add_byte($urandom_range(0, 9) == 0 ? ESC_CLEAR : 8'($urandom));
        end
        16: if ($urandom_range(0, 9) == 0) add_byte(BYTE_HOME);
        default: add_byte(8'($urandom));  // noise
      endcase
    end
  endfunction

  // Sender: bursts of random length separated by random gaps, some without gaps.
  initial begin
    int idx, burst;
    build_directed();
    build_random(290);
    idx = 0;
    repeat (3) @(posedge clk);
    rst <= 0;
    while (idx < items.size()) begin
      burst = $urandom_range(1, 20);
      while (burst > 0 && idx < items.size()) begin
        in_valid <= 1;
        command  <= items[idx].cmd;
        rx_byte  <= items[idx].b;
        read_row <= items[idx].r;
        read_col <= items[idx].c;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        idx++;
        burst--;
      end
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
    in_valid <= 0;
    stim_done = 1;
  end

  // Receiver stall pattern: stretches of random stalling and stretches of none.
  always @(posedge clk) begin
    if (hold_off) out_stall <= 1;
    else if ($realtime < 4000.0 || $realtime > 40000.0) out_stall <= $urandom_range(0, 3) == 0;
    else out_stall <= 0;
  end

  // One long hold-off early in the run so that the block backs up onto its input.
  initial begin
    @(negedge rst);
    repeat (5000) @(posedge clk);
    hold_off = 1;
    repeat (3000) @(posedge clk);
    hold_off = 0;
  end

  initial begin
    wait (stim_done);
    while (pending != 0) @(posedge clk);
    repeat (8000) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Timeout guard; scrolls, line moves and clears are the longest items.
  initial begin
    #20000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
